// ----- src/pspm_pkg.sv -----
// Package with payload, configuration and flag types for the power stage protection monitor.
`timescale 1ns / 1ps
package pspm_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_OVER_TRIP     = 3'd0,
    REG_IN_OVER_RELEASE  = 3'd1,
    REG_IN_UNDER_TRIP    = 3'd2,
    REG_IN_UNDER_RELEASE = 3'd3,
    REG_OUT_OVER_TRIP    = 3'd4,
    REG_CURRENT_LIMIT    = 3'd5,
    REG_TEMP_TRIP        = 3'd6,
    REG_TEMP_RELEASE     = 3'd7
  } cfg_reg_t;

  // Short-circuit detector thresholds
  localparam logic [15:0] SHORT_LOW_VOLTAGE = 16'd50;
  localparam logic [15:0] SHORT_CHECK_LIMIT = 16'd500;

  // Register reset values
  localparam logic [15:0]        IN_OVER_TRIP_RST  = 16'hFFFF;
  localparam logic [15:0]        OUT_OVER_TRIP_RST = 16'hFFFF;
  localparam logic [15:0]        CURRENT_LIMIT_RST = 16'hFFFF;
  localparam logic signed [15:0] TEMP_TRIP_RST     = 16'sh7FFF;
  localparam logic signed [15:0] TEMP_RELEASE_RST  = 16'sh8000;

  // One measurement set
  typedef struct packed {
    logic [15:0]        input_voltage;
    logic [15:0]        output_voltage;
    logic [15:0]        output_current;
    logic signed [15:0] temperature;
    logic               output_enabled;
    logic               power_good;
    logic               power_on_settled;
    logic [15:0]        short_check_ticks;
    logic               recovery_elapsed;
  } in_item_t;

  // One set of protection flags
  typedef struct packed {
    logic in_over_flag;
    logic in_under_flag;
    logic out_over_flag;
    logic over_current_flag;
    logic over_temp_flag;
    logic short_flag;
    logic maybe_short_flag;
  } out_item_t;

  // Threshold registers as seen by the flag logic
  typedef struct packed {
    logic [15:0]        in_over_trip;
    logic [15:0]        in_over_release;
    logic [15:0]        in_under_trip;
    logic [15:0]        in_under_release;
    logic [15:0]        out_over_trip;
    logic [15:0]        current_limit;
    logic signed [15:0] temp_trip;
    logic signed [15:0] temp_release;
  } cfg_t;

endpackage

// ----- src/power_stage_protection_monitor.sv -----
// Top level of the power stage protection monitor.
`timescale 1ns / 1ps
// Power stage protection monitor.
// Input channel (in_valid/in_ready/in_data) takes one measurement set per
// transfer; the result channel (out_valid/out_ready/out_data) returns one set
// of protection flags per measurement, in order.
// Thresholds are written through cfg_we/cfg_idx/cfg_data; the user writes
// them only while no sample is in flight, which the block does not enforce.
// A write takes effect at the next clock edge. A sample passes through the
// input register, then the flag update into the result register.
// Throughput: one sample per cycle while out_ready holds; the flag update is
// a single level of compares between the input and result registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more sample; in_ready drops once both are full.
// Synchronous reset empties both registers, clears all flags and loads the
// reset thresholds (over trips and limit at full scale, the rest at the bottom).
module power_stage_protection_monitor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pspm_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pspm_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [pspm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [pspm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pspm_pkg::*;

  cfg_t      cfg;
  in_item_t  item_r;
  logic      item_vld_r;
  out_item_t res_r;
  logic      res_vld_r;
  out_item_t flags;
  logic      res_load;

  pspm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  // Result register is free when empty or being drained
  assign res_load = item_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !item_vld_r || !res_vld_r || out_ready;

  pspm_eval u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (res_load),
    .item  (item_r),
    .cfg   (cfg),
    .flags (flags)
  );

  // Input register valid and result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        item_vld_r <= in_valid;
      end
      if (res_load) begin
        res_vld_r <= 1'b1;
      end else if (out_ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
    if (res_load) begin
      res_r <= flags;
    end
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

endmodule

// ----- src/pspm_cfg.sv -----
// Threshold register file written through the configuration port.
`timescale 1ns / 1ps
module pspm_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pspm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [pspm_pkg::CFG_DATA_W-1:0] cfg_data,
  output pspm_pkg::cfg_t                cfg
);
  import pspm_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_IN_OVER_TRIP:     cfg_nxt.in_over_trip     = cfg_data;
        REG_IN_OVER_RELEASE:  cfg_nxt.in_over_release  = cfg_data;
        REG_IN_UNDER_TRIP:    cfg_nxt.in_under_trip    = cfg_data;
        REG_IN_UNDER_RELEASE: cfg_nxt.in_under_release = cfg_data;
        REG_OUT_OVER_TRIP:    cfg_nxt.out_over_trip    = cfg_data;
        REG_CURRENT_LIMIT:    cfg_nxt.current_limit    = cfg_data;
        REG_TEMP_TRIP:        cfg_nxt.temp_trip        = $signed(cfg_data);
        REG_TEMP_RELEASE:     cfg_nxt.temp_release     = $signed(cfg_data);
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold the registers, load reset thresholds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_over_trip     <= IN_OVER_TRIP_RST;
      cfg_r.in_over_release  <= '0;
      cfg_r.in_under_trip    <= '0;
      cfg_r.in_under_release <= '0;
      cfg_r.out_over_trip    <= OUT_OVER_TRIP_RST;
      cfg_r.current_limit    <= CURRENT_LIMIT_RST;
      cfg_r.temp_trip        <= TEMP_TRIP_RST;
      cfg_r.temp_release     <= TEMP_RELEASE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/pspm_eval.sv -----
// Protection flag state and its per-sample update.
`timescale 1ns / 1ps
module pspm_eval (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 upd,
  input  pspm_pkg::in_item_t   item,
  input  pspm_pkg::cfg_t       cfg,
  output pspm_pkg::out_item_t  flags
);
  import pspm_pkg::*;

  logic in_over_r,    in_over_nxt;
  logic in_under_r,   in_under_nxt;
  logic out_over_r,   out_over_nxt;
  logic over_temp_r,  over_temp_nxt;
  logic short_r,      short_nxt;
  logic maybe_short_r, maybe_short_nxt;
  logic run_ok;

  assign run_ok = item.output_enabled && item.power_good && !short_r;

  // Work out the next flag state; trip wins over release
  always_comb begin
    in_over_nxt = in_over_r;
    if (item.input_voltage >= cfg.in_over_trip) begin
      in_over_nxt = 1'b1;
    end else if (item.input_voltage <= cfg.in_over_release) begin
      in_over_nxt = 1'b0;
    end

    in_under_nxt = in_under_r;
    if (item.input_voltage <= cfg.in_under_trip && item.power_on_settled) begin
      in_under_nxt = 1'b1;
    end else if (item.input_voltage >= cfg.in_under_release) begin
      in_under_nxt = 1'b0;
    end

    out_over_nxt = out_over_r || (item.output_voltage >= cfg.out_over_trip);

    over_temp_nxt = over_temp_r;
    if (item.temperature >= cfg.temp_trip && item.power_on_settled) begin
      over_temp_nxt = 1'b1;
    end else if (item.temperature <= cfg.temp_release) begin
      over_temp_nxt = 1'b0;
    end

    // Short-circuit detector: arm and trip while running, clear after recovery
    short_nxt       = short_r;
    maybe_short_nxt = maybe_short_r;
    if (run_ok) begin
      maybe_short_nxt = 1'b1;
      if (item.output_voltage <= SHORT_LOW_VOLTAGE &&
          item.short_check_ticks > SHORT_CHECK_LIMIT) begin
        short_nxt = 1'b1;
      end
    end else if (short_r && item.recovery_elapsed) begin
      short_nxt = 1'b0;
    end else if (item.output_enabled && !item.power_good) begin
      maybe_short_nxt = 1'b0;
    end
  end

  // Advance state when a sample is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_over_r     <= 1'b0;
      in_under_r    <= 1'b0;
      out_over_r    <= 1'b0;
      over_temp_r   <= 1'b0;
      short_r       <= 1'b0;
      maybe_short_r <= 1'b0;
    end else if (upd) begin
      in_over_r     <= in_over_nxt;
      in_under_r    <= in_under_nxt;
      out_over_r    <= out_over_nxt;
      over_temp_r   <= over_temp_nxt;
      short_r       <= short_nxt;
      maybe_short_r <= maybe_short_nxt;
    end
  end

  // Flags after this sample's update
  always_comb begin
    flags.in_over_flag      = in_over_nxt;
    flags.in_under_flag     = in_under_nxt;
    flags.out_over_flag     = out_over_nxt;
    flags.over_current_flag = item.output_current >= cfg.current_limit;
    flags.over_temp_flag    = over_temp_nxt;
    flags.short_flag        = short_nxt;
    flags.maybe_short_flag  = maybe_short_nxt;
  end

endmodule

// ----- src/pspm_checker.sv -----
// Port-level checker for the power stage protection monitor, with its bind.
`timescale 1ns / 1ps
module pspm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input pspm_pkg::out_item_t out_data
);
  import pspm_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Output over-voltage never clears once reported
  a_ov_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_over_flag |=> !out_valid || out_data.out_over_flag)
    else $error("output over-voltage latch cleared");

  // Input side is open whenever the result side can drain
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with result side free");

  // Reset empties the result register
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind power_stage_protection_monitor pspm_checker u_pspm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
